### hw/rtl/quaternion_normalize_defines.svh
// Assertion macros for the quaternion normalizer.
`ifndef QUATERNION_NORMALIZE_DEFINES_SVH
`define QUATERNION_NORMALIZE_DEFINES_SVH

// Condition holds in the same cycle as the trigger.
`define QN_ASSERT_NOW(lbl, clk, rst, trig, cond) \
   lbl: assert property (@(posedge clk) disable iff (rst) (trig) |-> (cond)) \
      else $error("quaternion_normalize check failed");

// Condition holds in the cycle after the trigger.
`define QN_ASSERT_NEXT(lbl, clk, rst, trig, cond) \
   lbl: assert property (@(posedge clk) disable iff (rst) (trig) |=> (cond)) \
      else $error("quaternion_normalize check failed");

`endif

### hw/rtl/qn_pkg.sv
// Types and constants shared by the quaternion normalizer modules.
`timescale 1ns / 1ps
`default_nettype none
package qn_pkg;
   localparam int QN_QW = 15;
   localparam int QN_SW = 33;
   localparam int QN_WW = 64;
   localparam int QN_LANES = 4;
   localparam int QN_NBITS = 15;
   localparam logic [QN_QW-1:0] QN_ONE = 15'd16384;

   typedef struct packed {
      logic [QN_SW-1:0]                 s;
      logic [QN_LANES-1:0][QN_WW-1:0]   rhs;
      logic [QN_LANES-1:0][QN_WW-1:0]   acc_a;
      logic [QN_LANES-1:0][QN_WW-1:0]   acc_b;
      logic [QN_LANES-1:0][QN_QW-1:0]   q;
      logic [QN_LANES-1:0]              neg;
   } qn_stage_type;
endpackage
`default_nettype wire

### hw/rtl/quaternion_normalize.sv
// Pipeline: 2 front stages, 15 bit cells, 1 output register.
// Throughput: one request per cycle; the whole pipeline stalls only while a
// result waits and rsp_ready is low.
// Each bit cell settles one result bit for all four components per cycle unless the pipeline stalls.
// Reset: synchronous, active high; clears all valid flags, payload is not reset.
`timescale 1ns / 1ps
`default_nettype none
`include "quaternion_normalize_defines.svh"
module quaternion_normalize (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic signed [15:0] req_in_x,
   input  logic signed [15:0] req_in_y,
   input  logic signed [15:0] req_in_z,
   input  logic signed [15:0] req_in_w,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic signed [15:0] rsp_out_x,
   output logic signed [15:0] rsp_out_y,
   output logic signed [15:0] rsp_out_z,
   output logic signed [15:0] rsp_out_w,
   output logic               rsp_zero_norm
);
   import qn_pkg::*;

   localparam int NVLD = QN_NBITS + 2;

   logic                              enable;
   logic [NVLD-1:0]                   vld_ff;
   logic [NVLD-1:0]                   vld_in;
   logic                              ovld_ff;
   logic                              ovld_in;
   qn_stage_type                      chain [QN_NBITS+1];
   logic [QN_LANES-1:0][15:0]         res_in;
   logic [QN_LANES-1:0][15:0]         res_ff;
   logic                              zero_in;
   logic                              zero_ff;
   logic                              res_nonzero;
   logic                              x_in_range;
   logic                              rsp_stall;

   assign enable    = rsp_ready || !ovld_ff;
   assign req_ready = enable;

   qn_front u_front (
      .clock    (clock),
      .enable   (enable),
      .in_x     (req_in_x),
      .in_y     (req_in_y),
      .in_z     (req_in_z),
      .in_w     (req_in_w),
      .down_stg (chain[0])
   );

   for (genvar g = 0; g < QN_NBITS; g++) begin : g_cell
      qn_cell #(.BIT(QN_NBITS - 1 - g)) u_cell (
         .clock    (clock),
         .enable   (enable),
         .up_stg   (chain[g]),
         .down_stg (chain[g+1])
      );
   end

   always_comb begin
      zero_in = (chain[QN_NBITS].s == '0);
      for (int i = 0; i < QN_LANES; i++) begin
         if (zero_in) begin
            res_in[i] = '0;
         end else if (chain[QN_NBITS].neg[i]) begin
            res_in[i] = 16'd0 - {1'b0, chain[QN_NBITS].q[i]};
         end else begin
            res_in[i] = {1'b0, chain[QN_NBITS].q[i]};
         end
      end
      vld_in  = {vld_ff[NVLD-2:0], req_valid};
      ovld_in = vld_ff[NVLD-1];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff  <= '0;
         ovld_ff <= 1'b0;
      end else if (enable) begin
         vld_ff  <= vld_in;
         ovld_ff <= ovld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         res_ff  <= res_in;
         zero_ff <= zero_in;
      end
   end

   assign rsp_valid     = ovld_ff;
   assign rsp_out_x     = res_ff[0];
   assign rsp_out_y     = res_ff[1];
   assign rsp_out_z     = res_ff[2];
   assign rsp_out_w     = res_ff[3];
   assign rsp_zero_norm = zero_ff;

   assign res_nonzero = (res_ff != '0);
   assign x_in_range  = (rsp_out_x <= 16'sd16384) && (rsp_out_x >= -16'sd16384);
   assign rsp_stall   = rsp_valid && !rsp_ready;

   `QN_ASSERT_NOW(a_zero_out, clock, reset, rsp_valid && rsp_zero_norm, !res_nonzero)
   `QN_ASSERT_NOW(a_nonzero_out, clock, reset, rsp_valid && !rsp_zero_norm, res_nonzero)
   `QN_ASSERT_NOW(a_x_range, clock, reset, rsp_valid, x_in_range)
   `QN_ASSERT_NEXT(a_stall_hold, clock, reset, rsp_stall, rsp_valid && $stable(rsp_out_w))
endmodule
`default_nettype wire

### hw/rtl/qn_front.sv
// Front end: magnitudes, squares, sum of squares and per-lane targets.
`timescale 1ns / 1ps
`default_nettype none
module qn_front (
   input  logic                      clock,
   input  logic                      enable,
   input  logic signed [15:0]        in_x,
   input  logic signed [15:0]        in_y,
   input  logic signed [15:0]        in_z,
   input  logic signed [15:0]        in_w,
   output qn_pkg::qn_stage_type      down_stg
);
   import qn_pkg::*;

   logic [QN_LANES-1:0][15:0] raw;
   logic [QN_LANES-1:0][16:0] mag;
   logic [QN_LANES-1:0][30:0] sq_ff;
   logic [QN_LANES-1:0][30:0] sq_in;
   logic [QN_LANES-1:0]       neg_ff;
   logic [QN_LANES-1:0]       neg_in;
   qn_stage_type              stage_ff;
   qn_stage_type              stage_in;

   assign raw = {in_w, in_z, in_y, in_x};

   always_comb begin
      for (int i = 0; i < QN_LANES; i++) begin
         neg_in[i] = raw[i][15];
         mag[i]    = raw[i][15] ? (17'd0 - {1'b1, raw[i]}) : {1'b0, raw[i]};
         sq_in[i]  = 31'(mag[i] * mag[i]);
      end
   end

   always_comb begin
      stage_in.s = QN_SW'(sq_ff[0]) + QN_SW'(sq_ff[1]) + QN_SW'(sq_ff[2])
                 + QN_SW'(sq_ff[3]);
      for (int i = 0; i < QN_LANES; i++) begin
         stage_in.rhs[i]   = QN_WW'(sq_ff[i]) << 30;
         stage_in.acc_a[i] = '0;
         stage_in.acc_b[i] = '0;
         stage_in.q[i]     = '0;
      end
      stage_in.neg = neg_ff;
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         sq_ff    <= sq_in;
         neg_ff   <= neg_in;
         stage_ff <= stage_in;
      end
   end

   assign down_stg = stage_ff;
endmodule
`default_nettype wire

### hw/rtl/qn_cell.sv
// One bit cell: decides one bit of each lane's scaled magnitude.
`timescale 1ns / 1ps
`default_nettype none
module qn_cell #(
   parameter int BIT = 14
) (
   input  logic                  clock,
   input  logic                  enable,
   input  qn_pkg::qn_stage_type  up_stg,
   output qn_pkg::qn_stage_type  down_stg
);
   import qn_pkg::*;

   logic [QN_WW-1:0]                 s64;
   logic [QN_LANES-1:0][QN_QW-1:0]   cand;
   logic [QN_LANES-1:0][QN_WW-1:0]   test;
   logic [QN_LANES-1:0]              take;
   qn_stage_type                     stage_ff;
   qn_stage_type                     stage_in;

   assign s64 = QN_WW'(up_stg.s);

   // (2c-1)^2 * S built from A = q^2*S and B = q*S with c = q + 2^BIT
   always_comb begin
      stage_in = up_stg;
      for (int i = 0; i < QN_LANES; i++) begin
         cand[i] = up_stg.q[i] | (QN_QW'(1) << BIT);
         test[i] = (up_stg.acc_a[i] << 2) + (up_stg.acc_b[i] << (BIT + 3))
                 + (s64 << (2 * BIT + 2)) - (up_stg.acc_b[i] << 2)
                 - (s64 << (BIT + 2)) + s64;
         take[i] = (cand[i] <= QN_ONE) && (test[i] <= up_stg.rhs[i]);
         if (take[i]) begin
            stage_in.q[i]     = cand[i];
            stage_in.acc_a[i] = up_stg.acc_a[i] + (up_stg.acc_b[i] << (BIT + 1))
                              + (s64 << (2 * BIT));
            stage_in.acc_b[i] = up_stg.acc_b[i] + (s64 << BIT);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         stage_ff <= stage_in;
      end
   end

   assign down_stg = stage_ff;
endmodule
`default_nettype wire

### test/quaternion_normalize_checker.sv
// Checker for the quaternion normalizer: predicts each request's result and compares.
`timescale 1ns / 1ps
module quaternion_normalize_checker (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   input  logic               req_ready,
   input  logic signed [15:0] req_in_x,
   input  logic signed [15:0] req_in_y,
   input  logic signed [15:0] req_in_z,
   input  logic signed [15:0] req_in_w,
   input  logic               rsp_valid,
   input  logic               rsp_ready,
   input  logic signed [15:0] rsp_out_x,
   input  logic signed [15:0] rsp_out_y,
   input  logic signed [15:0] rsp_out_z,
   input  logic signed [15:0] rsp_out_w,
   input  logic               rsp_zero_norm,
   output int                 error_count,
   output int                 pending,
   output int                 result_count,
   output int                 zero_count
);
   typedef struct {
      logic [15:0] x, y, z, w;
      logic        zn;
   } unit_quat_type;

   unit_quat_type unit_queue[$];

   initial begin
      error_count  = 0;
      result_count = 0;
      zero_count   = 0;
   end

   assign pending = unit_queue.size();

   function automatic logic [16:0] magnitude(logic [15:0] v);
      return v[15] ? 17'(17'h10000 - {1'b0, v}) : {1'b0, v};
   endfunction

   // correctly rounded 16384*a/sqrt(s), ties up
   function automatic logic [15:0] scaled_component(logic [15:0] v, logic [63:0] s);
      logic [63:0] a;
      logic [63:0] lim;
      logic [63:0] t;
      logic [15:0] q;
      logic [15:0] cand;
      a = 64'(magnitude(v));
      lim = (a * a) << 30;
      q = 0;
      for (int b = 14; b >= 0; b--) begin
         cand = q | (16'd1 << b);
         if (cand <= 16'd16384) begin
            t = 2 * 64'(cand) - 1;
            if (t * t * s <= lim) q = cand;
         end
      end
      if (v[15] && q != 0) return 16'(17'h10000 - 17'(q));
      return q;
   endfunction

   function automatic unit_quat_type normalize(logic [15:0] x, logic [15:0] y,
                                              logic [15:0] z, logic [15:0] w);
      unit_quat_type r;
      logic [63:0] s;
      s = 64'(magnitude(x)) ** 2 + 64'(magnitude(y)) ** 2
        + 64'(magnitude(z)) ** 2 + 64'(magnitude(w)) ** 2;
      if (s == 0) begin
         r = '{16'd0, 16'd0, 16'd0, 16'd0, 1'b1};
      end else begin
         r.x = scaled_component(x, s);
         r.y = scaled_component(y, s);
         r.z = scaled_component(z, s);
         r.w = scaled_component(w, s);
         r.zn = 1'b0;
      end
      return r;
   endfunction

   task automatic report(string what, logic [15:0] got, logic [15:0] want);
      $display("mismatch %s: got %h expected %h at %0t", what, got, want, $realtime);
      error_count++;
   endtask

   always @(posedge clock) begin
      unit_quat_type e;
      if (!reset) begin
         if (req_valid && req_ready)
            unit_queue.push_back(normalize(req_in_x, req_in_y, req_in_z, req_in_w));
         if (rsp_valid && rsp_ready) begin
            result_count++;
            if (rsp_zero_norm) zero_count++;
            if (unit_queue.size() == 0) begin
               report("unexpected result", rsp_out_x, 16'd0);
            end else begin
               e = unit_queue.pop_front();
               if (rsp_out_x !== e.x) report("out_x", rsp_out_x, e.x);
               if (rsp_out_y !== e.y) report("out_y", rsp_out_y, e.y);
               if (rsp_out_z !== e.z) report("out_z", rsp_out_z, e.z);
               if (rsp_out_w !== e.w) report("out_w", rsp_out_w, e.w);
               if (rsp_zero_norm !== e.zn) report("zero_norm", 16'(rsp_zero_norm), 16'(e.zn));
            end
         end
      end
   end
endmodule

### test/quaternion_normalize_tb.sv
// Testbench top for the quaternion normalizer: stimulus, stalls and verdict.
`timescale 1ns / 1ps
module quaternion_normalize_tb;
   localparam int RANDOM_REQUESTS = 830;
   localparam int LATENCY = 18;
   localparam longint CYCLE_LIMIT = 400000;

   logic               clock;
   logic               reset;
   logic               req_valid;
   logic               req_ready;
   logic signed [15:0] req_in_x, req_in_y, req_in_z, req_in_w;
   logic               rsp_valid;
   logic               rsp_ready;
   logic signed [15:0] rsp_out_x, rsp_out_y, rsp_out_z, rsp_out_w;
   logic               rsp_zero_norm;
   int                 error_count, pending, result_count, zero_count;
   int                 request_count;
   longint             cycle_count;
   logic               hold_off;

   quaternion_normalize u_top (.*);

   quaternion_normalize_checker u_checker (.*);

   initial begin
      clock = 0;
      forever #1 clock = ~clock;
   end

   initial begin
      cycle_count = 0;
      forever begin
         @(posedge clock);
         cycle_count++;
         if (cycle_count > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycle_count);
            $display("FAIL");
            $finish;
         end
      end
   end

   function automatic int gap_length();
      int r;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 93) return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   function automatic logic [15:0] random_component();
      case ($urandom_range(0, 7))
         0: return 16'h8000;
         1: return 16'h7fff;
         2: return 16'h0000;
         3: return 16'(signed'($urandom_range(0, 8)) - 4);
         4: return 16'($urandom_range(0, 255)) << $urandom_range(0, 8);
         default: return 16'($urandom);
      endcase
   endfunction

   // receiver: random stalls, plus one long hold-off
   initial begin
      int g;
      rsp_ready = 0;
      @(negedge clock);
      while (1) begin
         if (hold_off) begin
            rsp_ready <= 0;
            repeat (200) @(negedge clock);
            hold_off = 0;
         end
         g = $urandom_range(0, 3) == 0 ? gap_length() : 0;
         if (g > 0) begin
            rsp_ready <= 0;
            repeat (g) @(negedge clock);
         end
         rsp_ready <= 1;
         @(negedge clock);
      end
   end

   task automatic send(logic [15:0] x, logic [15:0] y, logic [15:0] z, logic [15:0] w);
      int g;
      g = gap_length();
      if (g > 0) begin
         req_valid <= 0;
         repeat (g) @(negedge clock);
      end
      req_valid <= 1;
      req_in_x <= x;
      req_in_y <= y;
      req_in_z <= z;
      req_in_w <= w;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      request_count++;
      @(negedge clock);
   endtask

   initial begin
      logic [15:0] edges[6];
      edges = '{16'h8000, 16'h7fff, 16'h0001, 16'hffff, 16'h4000, 16'hc000};
      hold_off = 0;
      request_count = 0;
      reset = 1;
      req_valid = 0;
      req_in_x = 0;
      req_in_y = 0;
      req_in_z = 0;
      req_in_w = 0;
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset = 0;

      send(0, 0, 0, 0);
      send(16'h8000, 16'h8000, 16'h8000, 16'h8000);
      send(16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff);
      send(16'h8000, 0, 0, 0);
      send(0, 16'h7fff, 0, 0);
      send(0, 0, 16'h0001, 0);
      send(0, 0, 0, 16'hffff);
      send(16'h4000, 0, 0, 0);
      send(1, 1, 1, 1);
      send(16'h8000, 16'h7fff, 16'h0001, 16'hffff);
      send(3, 4, 0, 0);
      send(0, 0, 0, 0);
      for (int i = 0; i < 8; i++)
         send(edges[$urandom_range(0, 5)], edges[$urandom_range(0, 5)],
              edges[$urandom_range(0, 5)], edges[$urandom_range(0, 5)]);

      hold_off = 1;
      for (int i = 0; i < RANDOM_REQUESTS; i++) begin
         if (i == RANDOM_REQUESTS / 2) begin
            req_valid <= 0;
            while (pending != 0) @(negedge clock);
         end
         if ($urandom_range(0, 49) == 0)
            send(0, 0, 0, 0);
         else
            send(random_component(), random_component(),
                 random_component(), random_component());
      end
      req_valid <= 0;

      while (pending != 0) @(negedge clock);
      repeat (LATENCY + 10) @(negedge clock);
      $display("sent %0d requests, checked %0d results (%0d zero norm)",
               request_count, result_count, zero_count);
      $display("covered full-scale, tiny and random quaternions under stalls and hold-offs");
      if (error_count == 0 && pending == 0)
         $display("PASS");
      else
         $display("FAIL");
      $finish;
   end
endmodule
